// ----- rtl/core/rtc_fields_to_epoch_check_defines.svh -----
// Assertion macros for the checker file of the RTC epoch converter.
`ifndef RTC_FIELDS_TO_EPOCH_CHECK_DEFINES_SVH
`define RTC_FIELDS_TO_EPOCH_CHECK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTCE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/rtce_pkg.sv -----
// Package with types, constants and the month-length function of the RTC epoch converter.
`timescale 1ns / 1ps
package rtce_pkg;

    // Calendar and time constants.
    localparam int unsigned MAX_YEAR_OFFSET = 69;
    localparam int unsigned BASE_YEAR       = 2000;
    localparam int unsigned EPOCH_YEAR      = 1970;
    localparam int unsigned SECS_PER_DAY    = 86400;
    localparam int unsigned SECS_PER_HOUR   = 3600;
    localparam int unsigned SECS_PER_MIN    = 60;
    localparam longint unsigned WINDOW_AHEAD = 366 * 86400;
    localparam int unsigned LAST_MONTH      = 11;
    localparam int unsigned LAST_HOUR       = 23;
    localparam int unsigned LAST_MINUTE     = 59;
    localparam int unsigned LAST_SECOND     = 59;
    // Earliest time a good reading can give: 2000-01-01 00:00:00.
    localparam longint unsigned MIN_EPOCH   = 946684800;

    // Widths of internal values.
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned DAYS_W  = 16;
    localparam int unsigned TOD_W   = 17;
    localparam int unsigned VALUE_W = 33;
    localparam int unsigned BUILD_W = 33;
    localparam int unsigned EPOCH_W = 32;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    step_year;
        logic    step_month;
        logic    mul;
        logic    sum;
        logic    out_write;
        t_status code;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic year_bad;
        logic field_bad;
        logic years_done;
        logic months_done;
        logic window_ok;
        logic out_free;
    } t_stat;

    // Length of a zero-based month, with February extended in leap years.
    function automatic logic [4:0] month_length(input logic [3:0] mon, input logic leap);
        logic [4:0] d;
        unique case (mon)
            4'd1:                   d = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
            default:                d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/core/rtce_ctrl.sv -----
// Controller state machine that sequences the checks, the day loops and the window test.
`timescale 1ns / 1ps
module rtce_ctrl import rtce_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CHECK  = 8'b0000_0010,
        S_YEARS  = 8'b0000_0100,
        S_MONTHS = 8'b0000_1000,
        S_MUL    = 8'b0001_0000,
        S_SUM    = 8'b0010_0000,
        S_WIN    = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    t_state  r_state, n_state;
    t_status r_code, n_code;

    // A new request is taken only when the previous one has left for the output register.
    assign o_in_ready = (r_state == S_IDLE);

    // Next state, pending result code and commands.
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.code = r_code;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.year_bad) begin
                    n_code  = ST_RANGE;
                    n_state = S_OUT;
                end else if (i_stat.field_bad) begin
                    n_code  = ST_INVALID;
                    n_state = S_OUT;
                end else begin
                    n_state = S_YEARS;
                end
            end
            S_YEARS: begin
                if (i_stat.years_done) begin
                    n_state = S_MONTHS;
                end else begin
                    o_cmd.step_year = 1'b1;
                end
            end
            S_MONTHS: begin
                if (i_stat.months_done) begin
                    n_state = S_MUL;
                end else begin
                    o_cmd.step_month = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_WIN;
            end
            S_WIN: begin
                n_code  = i_stat.window_ok ? ST_OK : ST_RANGE;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_write = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and code registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

endmodule

// ----- rtl/core/rtce_dp.sv -----
// Datapath: field registers, day accumulator, seconds arithmetic, window test and output register.
`timescale 1ns / 1ps
module rtce_dp import rtce_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [BUILD_W-1:0]   i_cfg_data,
    input  logic [7:0]           i_year_offset,
    input  logic [3:0]           i_month_index,
    input  logic [4:0]           i_day_of_month,
    input  logic [4:0]           i_hour_value,
    input  logic [5:0]           i_minute_value,
    input  logic [5:0]           i_second_value,
    input  logic                 i_out_ready,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output logic                 o_out_valid,
    output logic [1:0]           o_status,
    output logic [EPOCH_W-1:0]   o_epoch_seconds
);

    logic [BUILD_W-1:0] r_build;
    logic [7:0]         r_yoff;
    logic [3:0]         r_mon;
    logic [4:0]         r_day;
    logic [4:0]         r_hr;
    logic [5:0]         r_mi;
    logic [5:0]         r_se;
    logic [YEAR_W-1:0]  r_year;
    logic [3:0]         r_month;
    logic [DAYS_W-1:0]  r_days;
    logic [VALUE_W-1:0] r_prod;
    logic [TOD_W-1:0]   r_tod;
    logic [VALUE_W-1:0] r_value;
    logic               r_out_valid;
    t_status            r_status;
    logic [EPOCH_W-1:0] r_epoch;

    logic               target_leap;
    logic [YEAR_W-1:0]  target_year;
    logic [4:0]         target_dim;
    logic [8:0]         year_len;
    logic [DAYS_W-1:0]  n_day_total;
    logic [BUILD_W:0]   window_hi;
    logic               low_ok;
    logic               high_ok;

    // The target year is a leap year whenever its offset from 2000 is a multiple of four.
    assign target_leap = (r_yoff[1:0] == 2'b00);
    assign target_year = YEAR_W'(BASE_YEAR) + YEAR_W'(r_yoff);
    assign target_dim  = month_length(r_mon, target_leap);

    // Between 1970 and 2099 the only leap rule that matters is divisibility by four.
    assign year_len    = (r_year[1:0] == 2'b00) ? 9'd366 : 9'd365;
    assign n_day_total = r_days + DAYS_W'(r_day) - DAYS_W'(1);

    // Window bounds around the build epoch.
    assign window_hi = {1'b0, r_build} + (BUILD_W + 1)'(WINDOW_AHEAD);
    assign low_ok    = (r_build >= BUILD_W'(SECS_PER_DAY)) &&
                       (r_value >= r_build - BUILD_W'(SECS_PER_DAY));
    assign high_ok   = ({1'b0, r_value} <= window_hi);

    // Status toward the controller.
    always_comb begin
        o_stat.year_bad    = (r_yoff > 8'(MAX_YEAR_OFFSET));
        o_stat.field_bad   = (r_mon > 4'(LAST_MONTH)) || (r_day == 5'd0) ||
                             (r_day > target_dim) || (r_hr > 5'(LAST_HOUR)) ||
                             (r_mi > 6'(LAST_MINUTE)) || (r_se > 6'(LAST_SECOND));
        o_stat.years_done  = (r_year == target_year);
        o_stat.months_done = (r_month == r_mon);
        o_stat.window_ok   = low_ok && high_ok;
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    // Build epoch register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_build <= '0;
        end else if (i_cfg_we) begin
            r_build <= i_cfg_data;
        end
    end

    // Request fields, loop counters and arithmetic.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_yoff  <= i_year_offset;
            r_mon   <= i_month_index;
            r_day   <= i_day_of_month;
            r_hr    <= i_hour_value;
            r_mi    <= i_minute_value;
            r_se    <= i_second_value;
            r_year  <= YEAR_W'(EPOCH_YEAR);
            r_month <= 4'd0;
            r_days  <= '0;
        end
        if (i_cmd.step_year) begin
            r_year <= r_year + YEAR_W'(1);
            r_days <= r_days + DAYS_W'(year_len);
        end
        if (i_cmd.step_month) begin
            r_month <= r_month + 4'd1;
            r_days  <= r_days + DAYS_W'(month_length(r_month, target_leap));
        end
        if (i_cmd.mul) begin
            r_prod <= VALUE_W'({17'b0, n_day_total} * VALUE_W'(SECS_PER_DAY));
            r_tod  <= TOD_W'({12'b0, r_hr} * TOD_W'(SECS_PER_HOUR)) +
                      TOD_W'({11'b0, r_mi} * TOD_W'(SECS_PER_MIN)) +
                      TOD_W'(r_se);
        end
        if (i_cmd.sum) begin
            r_value <= r_prod + VALUE_W'(r_tod);
        end
    end

    // Output register, freed when the downstream side takes the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_write) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_write) begin
            r_status <= i_cmd.code;
            r_epoch  <= (i_cmd.code == ST_OK) ? r_value[EPOCH_W-1:0] : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_epoch_seconds = r_epoch;

endmodule

// ----- rtl/core/rtc_fields_to_epoch_check.sv -----
// Top level of the RTC reading to Unix epoch converter with range checks.
//
//   Channel  Direction  Handshake                     Payload
//   in       request    i_in_valid / o_in_ready       year, month, day, hour, minute, second
//   out      result     o_out_valid / i_out_ready     o_status, o_epoch_seconds
//   cfg      write      i_cfg_we                      i_cfg_data (build epoch)
//
// A request failing the year or field checks goes from the check to the output state; others
// run the year loop from 1970, one year per cycle, then months, multiply, sum and window test.
// One request is in work at a time; the next is taken as soon as the result is in the
// output register, even while that result waits for i_out_ready.
// Reset is synchronous and active low; it clears the controller, the output valid and the
// build epoch. A stalled output holds the finished request in the last state.
`timescale 1ns / 1ps
module rtc_fields_to_epoch_check import rtce_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [BUILD_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_year_offset,
    input  logic [3:0]           i_month_index,
    input  logic [4:0]           i_day_of_month,
    input  logic [4:0]           i_hour_value,
    input  logic [5:0]           i_minute_value,
    input  logic [5:0]           i_second_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_status,
    output logic [EPOCH_W-1:0]   o_epoch_seconds
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    rtce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Arithmetic and storage.
    rtce_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_year_offset   (i_year_offset),
        .i_month_index   (i_month_index),
        .i_day_of_month  (i_day_of_month),
        .i_hour_value    (i_hour_value),
        .i_minute_value  (i_minute_value),
        .i_second_value  (i_second_value),
        .i_out_ready     (i_out_ready),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_epoch_seconds (o_epoch_seconds)
    );

endmodule

// ----- rtl/core/rtce_check.sv -----
// Port-level checker for the RTC epoch converter and its bind to the top level.
`timescale 1ns / 1ps
`include "rtc_fields_to_epoch_check_defines.svh"
module rtce_check import rtce_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [1:0]           o_status,
    input logic [EPOCH_W-1:0]   o_epoch_seconds
);

    // A stalled result keeps its valid and its payload.
    `RTCE_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_epoch_seconds), "stalled result changed")

    // Any failing status carries a zero time.
    `RTCE_ASSERT_NOW(a_err_zero, o_out_valid && (o_status != ST_OK), o_epoch_seconds == '0, "error result with nonzero time")

    // A good result never lies before the start of 2000.
    `RTCE_ASSERT_NOW(a_ok_min, o_out_valid && (o_status == ST_OK), o_epoch_seconds >= EPOCH_W'(MIN_EPOCH), "good result before 2000")

    // Once a request is taken the block is busy in the next cycle.
    `RTCE_ASSERT_NEXT(a_busy, i_in_valid && o_in_ready, !o_in_ready, "ready right after a request")

endmodule

bind rtc_fields_to_epoch_check rtce_check u_rtce_check (.*);

// ----- tb/rtc_epoch_monitor.sv -----
// Checker that predicts the result of each RTC reading and compares it with the block output.
`timescale 1ns / 1ps
module rtc_epoch_monitor import rtce_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [BUILD_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [7:0]         i_year_offset,
    input  logic [3:0]         i_month_index,
    input  logic [4:0]         i_day_of_month,
    input  logic [4:0]         i_hour_value,
    input  logic [5:0]         i_minute_value,
    input  logic [5:0]         i_second_value,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [1:0]         i_status,
    input  logic [EPOCH_W-1:0] i_epoch_seconds,
    output int                 o_fail_count,
    output int                 o_pending
);

    // Non-leap month lengths, January first.
    localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        t_status              status;
        logic [EPOCH_W-1:0]   seconds;
    } t_epoch_verdict;

    logic [BUILD_W-1:0] build_anchor;
    t_epoch_verdict     due_q[$];

    function automatic bit leap_year(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic int unsigned days_of_month(input int unsigned yr, input int unsigned mon);
        return MONTH_LEN[mon] + ((mon == 1 && leap_year(yr)) ? 1 : 0);
    endfunction

    // Expected status and Unix seconds for one reading under the given build epoch.
    function automatic t_epoch_verdict convert_reading(
        input logic [7:0]         yoff,
        input logic [3:0]         mon,
        input logic [4:0]         day,
        input logic [4:0]         hr,
        input logic [5:0]         mi,
        input logic [5:0]         se,
        input logic [BUILD_W-1:0] anchor
    );
        t_epoch_verdict  v;
        int unsigned     yr;
        int unsigned     y;
        int unsigned     m;
        bit              bad;
        longint unsigned days;
        longint unsigned secs;
        longint unsigned lo;
        longint unsigned hi;
        v.status  = ST_RANGE;
        v.seconds = '0;
        // The year check wins over every field check.
        if (yoff > MAX_YEAR_OFFSET) begin
            return v;
        end
        yr  = BASE_YEAR + yoff;
        bad = (mon > LAST_MONTH) || (day == 0) || (hr > LAST_HOUR) ||
              (mi > LAST_MINUTE) || (se > LAST_SECOND);
        if (!bad) begin
            bad = day > days_of_month(yr, mon);
        end
        if (bad) begin
            v.status = ST_INVALID;
            return v;
        end
        // Whole days since 1970-01-01, then the time of day.
        days = 0;
        for (y = EPOCH_YEAR; y < yr; y++) begin
            days += leap_year(y) ? 366 : 365;
        end
        for (m = 0; m < mon; m++) begin
            days += days_of_month(yr, m);
        end
        days += day - 1;
        secs = days * SECS_PER_DAY + longint'(hr) * SECS_PER_HOUR +
               longint'(mi) * SECS_PER_MIN + longint'(se);
        // Accepted window: one day before the build epoch up to 366 days after it.
        lo = longint'(anchor) - SECS_PER_DAY;
        hi = longint'(anchor) + WINDOW_AHEAD;
        if (anchor < SECS_PER_DAY || secs < lo || secs > hi) begin
            return v;
        end
        v.status  = ST_OK;
        v.seconds = secs[EPOCH_W-1:0];
        return v;
    endfunction

    // Track the build epoch, queue predictions on accepted requests, check accepted results.
    always @(posedge i_clk) begin
        t_epoch_verdict want;
        int             errs;
        errs = 0;
        if (!i_rst_n) begin
            build_anchor <= '0;
            due_q.delete();
            o_pending    <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (due_q.size() == 0) begin
                    $error("unexpected result: status %0d, epoch_seconds %0d",
                           i_status, i_epoch_seconds);
                    errs++;
                end else begin
                    want = due_q.pop_front();
                    if (i_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_status);
                        errs++;
                    end
                    if (i_epoch_seconds !== want.seconds) begin
                        $error("epoch_seconds mismatch: expected %0d, actual %0d",
                               want.seconds, i_epoch_seconds);
                        errs++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                due_q.push_back(convert_reading(i_year_offset, i_month_index, i_day_of_month,
                                                i_hour_value, i_minute_value, i_second_value,
                                                build_anchor));
            end
            if (i_cfg_we) begin
                build_anchor <= i_cfg_data;
            end
            o_pending <= due_q.size();
        end
        o_fail_count <= o_fail_count + errs;
    end

endmodule

// ----- tb/testbench.sv -----
// Testbench top: clock, reset, RTC requests, build epoch writes and the final verdict.
`timescale 1ns / 1ps
module testbench;
    import rtce_pkg::*;

    // Unix seconds of 2069-12-31 23:59:59, the latest reading the block can accept.
    localparam longint unsigned LAST_READING_EPOCH = 64'd3155759999;
    localparam longint unsigned ANCHOR_MAX         = 64'h1_FFFF_FFFF;
    localparam longint unsigned AVG_YEAR_SECS      = 64'd31556952;
    localparam int              ITEMS_PER_PHASE    = 150;
    localparam int              RANDOM_PHASES      = 6;
    localparam int              TAIL_CYCLES        = 128;

    typedef enum {
        PLAN_SLOW_SINK,
        PLAN_SLOW_SOURCE,
        PLAN_NO_IDLE
    } t_idle_plan;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_cfg_we        = 1'b0;
    logic [BUILD_W-1:0] i_cfg_data      = '0;
    logic               i_in_valid      = 1'b0;
    logic [7:0]         i_year_offset   = '0;
    logic [3:0]         i_month_index   = '0;
    logic [4:0]         i_day_of_month  = '0;
    logic [4:0]         i_hour_value    = '0;
    logic [5:0]         i_minute_value  = '0;
    logic [5:0]         i_second_value  = '0;
    logic               i_out_ready     = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [1:0]         o_status;
    logic [EPOCH_W-1:0] o_epoch_seconds;

    int fail_count;
    int pending_count;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    rtc_fields_to_epoch_check dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_year_offset   (i_year_offset),
        .i_month_index   (i_month_index),
        .i_day_of_month  (i_day_of_month),
        .i_hour_value    (i_hour_value),
        .i_minute_value  (i_minute_value),
        .i_second_value  (i_second_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_epoch_seconds (o_epoch_seconds)
    );

    rtc_epoch_monitor u_monitor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_year_offset   (i_year_offset),
        .i_month_index   (i_month_index),
        .i_day_of_month  (i_day_of_month),
        .i_hour_value    (i_hour_value),
        .i_minute_value  (i_minute_value),
        .i_second_value  (i_second_value),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_status        (o_status),
        .i_epoch_seconds (o_epoch_seconds),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Result side: randomly hold off ready according to the current idle plan.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Hard stop in case the block hangs.
    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic set_idle(input t_idle_plan plan);
        case (plan)
            PLAN_SLOW_SINK: begin
                send_idle_pct = 14;
                recv_idle_pct = 88;
            end
            PLAN_SLOW_SOURCE: begin
                send_idle_pct = 88;
                recv_idle_pct = 14;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Present one request, after an optional random gap, and hold it until it is taken.
    task automatic send_reading(
        input logic [7:0] yoff,
        input logic [3:0] mon,
        input logic [4:0] day,
        input logic [4:0] hr,
        input logic [5:0] mi,
        input logic [5:0] se
    );
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_year_offset  <= yoff;
        i_month_index  <= mon;
        i_day_of_month <= day;
        i_hour_value   <= hr;
        i_minute_value <= mi;
        i_second_value <= se;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stop sending and wait until every expected result has come out.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    // Write the build epoch once the block is idle.
    task automatic write_anchor(input longint unsigned value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value[BUILD_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        longint unsigned anchor;
        int unsigned     anchor_year;
        int              yr;
        int              pick;
        int              phase;
        int              n;
        logic [7:0]      yv;
        logic [3:0]      mv;
        logic [4:0]      dv;
        logic [4:0]      hv;
        logic [5:0]      nv;
        logic [5:0]      sv;

        set_idle(PLAN_SLOW_SINK);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Build epoch is zero after reset, so even good readings fail the window.
        send_reading(69, 11, 31, 23, 59, 59);
        send_reading(0, 0, 1, 0, 0, 0);
        send_reading(70, 0, 1, 0, 0, 0);
        send_reading(255, 15, 31, 31, 63, 63);
        send_reading(0, 12, 1, 0, 0, 0);
        send_reading(0, 15, 1, 0, 0, 0);
        send_reading(0, 0, 0, 0, 0, 0);
        send_reading(1, 3, 31, 0, 0, 0);
        // Leap February: 2000 and 2004 have a 29th, 2001 does not.
        send_reading(0, 1, 29, 12, 0, 0);
        send_reading(1, 1, 29, 12, 0, 0);
        send_reading(4, 1, 29, 12, 0, 0);
        send_reading(5, 6, 15, 24, 0, 0);
        send_reading(5, 6, 15, 31, 0, 0);
        send_reading(5, 6, 15, 10, 60, 0);
        send_reading(5, 6, 15, 10, 63, 0);
        send_reading(5, 6, 15, 10, 0, 60);
        send_reading(5, 6, 15, 10, 0, 63);

        // A build epoch below one day rejects everything; one day is still far too early.
        write_anchor(SECS_PER_DAY - 1);
        send_reading(0, 0, 1, 0, 0, 0);
        write_anchor(SECS_PER_DAY);
        send_reading(0, 0, 1, 0, 0, 0);

        // Lower window edge at 2000-01-01 00:00:00, then one second past it.
        write_anchor(MIN_EPOCH + SECS_PER_DAY);
        send_reading(0, 0, 1, 0, 0, 0);
        send_reading(0, 0, 2, 0, 0, 0);
        write_anchor(MIN_EPOCH + SECS_PER_DAY + 1);
        send_reading(0, 0, 1, 0, 0, 0);
        send_reading(0, 0, 1, 0, 0, 1);

        // Upper window edge: 366 days after 2000-01-01 is 2001-01-01 00:00:00.
        write_anchor(MIN_EPOCH);
        send_reading(1, 0, 1, 0, 0, 0);
        send_reading(1, 0, 1, 0, 0, 1);
        send_reading(0, 11, 31, 23, 59, 59);

        // Latest reading at the lower edge, and the largest build epoch.
        write_anchor(LAST_READING_EPOCH + SECS_PER_DAY);
        send_reading(69, 11, 31, 23, 59, 59);
        send_reading(69, 11, 31, 23, 59, 58);
        write_anchor(ANCHOR_MAX);
        send_reading(69, 11, 31, 23, 59, 59);

        // Random phases, each with its own build epoch; idle plan changes every two phases.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_idle(t_idle_plan'(phase / 2));
            anchor_year = $urandom_range(0, MAX_YEAR_OFFSET);
            anchor = MIN_EPOCH + anchor_year * AVG_YEAR_SECS +
                     $urandom_range(0, 32'(AVG_YEAR_SECS - 1));
            write_anchor(anchor);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                // Mostly good readings in the years around the build epoch.
                yr = int'(anchor_year) + int'($urandom_range(0, 2)) - 1;
                if (yr < 0) begin
                    yr = 0;
                end
                if (yr > MAX_YEAR_OFFSET) begin
                    yr = MAX_YEAR_OFFSET;
                end
                yv = 8'(yr);
                mv = 4'($urandom_range(0, LAST_MONTH));
                dv = 5'(($urandom_range(0, 9) == 0) ? $urandom_range(29, 31) :
                                                      $urandom_range(1, 28));
                hv = 5'($urandom_range(0, LAST_HOUR));
                nv = 6'($urandom_range(0, LAST_MINUTE));
                sv = 6'($urandom_range(0, LAST_SECOND));
                if (pick >= 70 && pick < 85) begin
                    // Any legal year with one field forced out of range.
                    yv = 8'($urandom_range(0, MAX_YEAR_OFFSET));
                    case ($urandom_range(0, 4))
                        0:       mv = 4'($urandom_range(12, 15));
                        1:       dv = '0;
                        2:       hv = 5'($urandom_range(24, 31));
                        3:       nv = 6'($urandom_range(60, 63));
                        default: sv = 6'($urandom_range(60, 63));
                    endcase
                end else if (pick >= 85) begin
                    // Raw noise over the full width of every field.
                    yv = 8'($urandom);
                    mv = 4'($urandom);
                    dv = 5'($urandom);
                    hv = 5'($urandom);
                    nv = 6'($urandom);
                    sv = 6'($urandom);
                end
                send_reading(yv, mv, dv, hv, nv, sv);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
